// ===== design/hid_report_packetizer_top_macros.svh =====
// Assertion macros for the HID report packetizer.
// Each expects aclk and aresetn in the scope of use.
`ifndef HID_REPORT_PACKETIZER_TOP_MACROS_SVH
`define HID_REPORT_PACKETIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define HRP_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

`define HRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define HRP_ASSERT_IMPLIES(lbl, ante, cons)

`define HRP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/hrp_pkg.sv =====
`default_nettype none

package hrp_pkg;

    localparam int MAX_REPORT     = 64;
    localparam int MIN_REPORT     = 8;
    localparam int FIRST_OVERHEAD = 4;
    localparam int TAIL_BYTES     = 2;
    localparam int QUEUE_DEPTH    = 2;

    localparam int SIZE_W = 7;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;

    // One classified request handed from front to back.
    typedef struct packed {
        logic              is_start;
        logic [BYTE_W-1:0] pb;
        logic [LEN_W-1:0]  len;
        logic              last;
    } cmd_t;

endpackage

`default_nettype wire

// ===== design/hrp_cmd_fifo.sv =====
`default_nettype none

module hrp_cmd_fifo #(
    parameter int DEPTH = hrp_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  hrp_pkg::cmd_t    push_cmd,
    input  wire logic        pop,
    output hrp_pkg::cmd_t    head_cmd,
    output logic             full,
    output logic             empty
);
    import hrp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== design/hrp_front.sv =====
`default_nettype none

module hrp_front #(
    parameter int MAX_REPORT_P = hrp_pkg::MAX_REPORT
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [hrp_pkg::SIZE_W-1:0] cfg_wr_data,
    input  wire logic                       in_valid,
    input  wire logic                       in_start,
    input  wire logic [hrp_pkg::BYTE_W-1:0] in_pb,
    input  wire logic [hrp_pkg::LEN_W-1:0]  in_len,
    input  wire logic                       queue_full,
    output logic                            in_ready,
    output logic                            push,
    output hrp_pkg::cmd_t                   push_cmd,
    output logic [hrp_pkg::SIZE_W-1:0]      limit
);
    import hrp_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [SIZE_W-1:0] eff_size;
    logic              accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        if (size_reg < SIZE_W'(MIN_REPORT)) begin
            eff_size = SIZE_W'(MIN_REPORT);
        end else if (size_reg > SIZE_W'(MAX_REPORT_P)) begin
            eff_size = SIZE_W'(MAX_REPORT_P);
        end else begin
            eff_size = size_reg;
        end
        limit = eff_size - SIZE_W'(TAIL_BYTES);
    end

    always_comb begin
        rem_next          = rem_reg;
        push              = 1'b0;
        push_cmd.is_start = in_start;
        push_cmd.pb       = in_pb;
        push_cmd.len      = in_len;
        push_cmd.last     = in_start ? (in_len <= LEN_W'(1)) : (rem_reg == LEN_W'(1));
        if (accept) begin
            if (in_start) begin
                push     = 1'b1;
                rem_next = (in_len == '0) ? '0 : in_len - LEN_W'(1);
            end else if (rem_reg != '0) begin
                push     = 1'b1;
                rem_next = rem_reg - LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_W'(MAX_REPORT_P);
            rem_reg  <= '0;
        end else begin
            rem_reg <= rem_next;
            // size is frozen while a message is open
            if (cfg_wr_en && rem_reg == '0) begin
                size_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/hrp_back.sv =====
`default_nettype none

`include "hid_report_packetizer_top_macros.svh"

module hrp_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       q_empty,
    input  hrp_pkg::cmd_t                   q_cmd,
    input  wire logic [hrp_pkg::SIZE_W-1:0] limit,
    output logic                            pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [hrp_pkg::BYTE_W-1:0]      out_data,
    output logic                            out_last,
    output logic                            out_msg_end
);
    import hrp_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_HI   = 7'b0000010,
        ST_LO   = 7'b0000100,
        ST_PB   = 7'b0001000,
        ST_PAD  = 7'b0010000,
        ST_CHK  = 7'b0100000,
        ST_ZERO = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [SIZE_W-1:0] pos_reg, pos_next;
    logic [BYTE_W-1:0] acc_reg, acc_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic              out_msg_reg, out_msg_next;

    logic              load;
    logic              emit;
    logic              is_data;
    logic [BYTE_W-1:0] eb;
    logic              elast;
    logic              emsg;
    logic [SIZE_W-1:0] pos_inc;
    logic              closing;

    function automatic state_t after_data(input logic last, input logic [SIZE_W-1:0] pos1,
                                          input logic [SIZE_W-1:0] lim);
        state_t s;
        if (last && pos1 < lim) begin
            s = ST_PAD;
        end else if (pos1 >= lim) begin
            s = ST_CHK;
        end else begin
            s = ST_IDLE;
        end
        return s;
    endfunction

    assign load    = !out_valid_reg || out_ready;
    assign pos_inc = pos_reg + SIZE_W'(1);
    assign closing = (state_reg == ST_ZERO) && load;

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        is_data    = 1'b0;
        eb         = '0;
        elast      = 1'b0;
        emsg       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    pop      = 1'b1;
                    cmd_next = q_cmd;
                    if (q_cmd.is_start) begin
                        pos_next   = '0;
                        acc_next   = '0;
                        state_next = ST_HI;
                    end else begin
                        state_next = ST_PB;
                    end
                end
            end
            ST_HI: begin
                if (load) begin
                    emit       = 1'b1;
                    is_data    = 1'b1;
                    eb         = cmd_reg.len[15:8];
                    state_next = ST_LO;
                end
            end
            ST_LO: begin
                if (load) begin
                    emit       = 1'b1;
                    is_data    = 1'b1;
                    eb         = cmd_reg.len[7:0];
                    state_next = (cmd_reg.len == '0) ?
                                 after_data(cmd_reg.last, pos_inc, limit) : ST_PB;
                end
            end
            ST_PB: begin
                if (load) begin
                    emit       = 1'b1;
                    is_data    = 1'b1;
                    eb         = cmd_reg.pb;
                    state_next = after_data(cmd_reg.last, pos_inc, limit);
                end
            end
            ST_PAD: begin
                if (load) begin
                    emit       = 1'b1;
                    is_data    = 1'b1;
                    state_next = after_data(cmd_reg.last, pos_inc, limit);
                end
            end
            ST_CHK: begin
                if (load) begin
                    emit       = 1'b1;
                    eb         = acc_reg;
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (load) begin
                    emit       = 1'b1;
                    elast      = 1'b1;
                    emsg       = cmd_reg.last;
                    pos_next   = '0;
                    acc_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (emit && is_data) begin
            acc_next = acc_reg ^ eb;
            pos_next = pos_inc;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_msg_next   = out_msg_reg;
        if (load) begin
            out_valid_next = emit;
            out_data_next  = eb;
            out_last_next  = elast;
            out_msg_next   = emsg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_msg_reg  <= out_msg_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;
    assign out_last    = out_last_reg;
    assign out_msg_end = out_msg_reg;

    `HRP_ASSERT_IMPLIES(a_msg_end_closes_report, out_valid_reg && out_msg_reg, out_last_reg)
    `HRP_ASSERT_IMPLIES(a_closing_byte_zero, out_valid_reg && out_last_reg, out_data_reg == '0)
    `HRP_ASSERT_NEXT(a_close_clears, closing, state_reg == ST_IDLE && pos_reg == '0 && acc_reg == '0)

endmodule

`default_nettype wire

// ===== design/hid_report_packetizer_top.sv =====
`default_nettype none

// HID report packetizer. Messages arrive one byte per request; the first request of a
// message carries its length and tuser=1. Each message leaves as P-byte reports, one byte
// per request: the first report opens with the big-endian length, byte P-2 of each report
// is the XOR of the bytes before it, byte P-1 is zero and has tlast; tuser marks the last
// report. The front side takes one request per cycle while the queue is not full into a
// two-entry command queue; the back sequencer fetches a command, then emits its bytes: a
// payload request gives its byte, a start the two length bytes and then its payload byte
// (only the length bytes if empty); a request that closes a report adds the XOR and zero
// bytes, and the last of a message pads with zeros first. m_tready low stalls the output.
// report_size is clamped to 8..MAX_REPORT_P and a write is dropped while a message is open.
module hid_report_packetizer_top #(
    parameter int MAX_REPORT_P  = hrp_pkg::MAX_REPORT,
    parameter int QUEUE_DEPTH_P = hrp_pkg::QUEUE_DEPTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [hrp_pkg::SIZE_W-1:0] cfg_wr_data,   // report_size
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [23:0]                s_tdata,       // payload_byte, message_length
    input  wire logic                       s_tuser,       // message_start
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [7:0]                      m_tdata,       // report_byte
    output logic                            m_tlast,       // report_end
    output logic                            m_tuser        // message_end
);
    import hrp_pkg::*;

    cmd_t              push_cmd, head_cmd;
    logic              push, pop, q_full, q_empty;
    logic [SIZE_W-1:0] limit;

    hrp_front #(
        .MAX_REPORT_P(MAX_REPORT_P)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (s_tvalid),
        .in_start   (s_tuser),
        .in_pb      (s_tdata[7:0]),
        .in_len     (s_tdata[23:8]),
        .queue_full (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_cmd   (push_cmd),
        .limit      (limit)
    );

    hrp_cmd_fifo #(
        .DEPTH(QUEUE_DEPTH_P)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .head_cmd(head_cmd),
        .full    (q_full),
        .empty   (q_empty)
    );

    hrp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_cmd      (head_cmd),
        .limit      (limit),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_last   (m_tlast),
        .out_msg_end(m_tuser)
    );

endmodule

`default_nettype wire
